// ===== src/xbin_pkg.sv =====
// Shared types and constants for the XBin cell stream decoder.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package xbin_pkg;

  // Field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned NibW   = 4;
  localparam int unsigned PosW   = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgAW  = 2;
  localparam int unsigned LeftW  = 7;
  localparam int unsigned CellW  = ByteW + 2 * NibW + 2 * PosW;

  // Reset values of the configuration registers
  localparam logic [CfgW-1:0] ColumnsReset = 16'd80;
  localparam logic [CfgW-1:0] RowsReset    = 16'd25;

  // Configuration register indexes
  typedef enum logic [CfgAW-1:0] {
    CFG_COLUMNS    = 2'd0,
    CFG_ROWS       = 2'd1,
    CFG_COMPRESSED = 2'd2
  } cfg_idx_e;

  // Run types of a compressed run header (bits 7..6)
  typedef enum logic [1:0] {
    RUN_LITERAL = 2'd0,
    RUN_CHAR    = 2'd1,
    RUN_ATTR    = 2'd2,
    RUN_BOTH    = 2'd3
  } run_type_e;

  // Controller to datapath commands
  typedef struct packed {
    logic ld_char;         // held character <= input byte
    logic ld_attr;         // held attribute <= input byte
    logic ld_head;         // run type and count <= header byte
    logic emit;            // try to place one cell in the output register
    logic char_from_byte;  // cell character comes from the input byte
    logic attr_from_byte;  // cell attribute comes from the input byte
    logic last;            // cell is the final one for its byte
    logic dec_left;        // one cell of the run is used up
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic      compressed;  // current mode
    logic      mode_wr;     // mode register written this cycle
    logic      finished;    // image complete, all bytes ignored
    logic      left_one;    // one cell left in the run
    logic      slot_free;   // output register can take a cell this cycle
    run_type_e run_type;
  } dp_status_t;

endpackage

// ===== src/xbin_cell_stream_decoder.sv =====
// XBin cell stream decoder: top level joining controller and datapath.
// Depends on xbin_pkg, xbin_ctrl and xbin_datapath.
`timescale 1ns / 1ps

// Takes the cell-data bytes of an XBin image on the slave stream, one byte
// per cycle, and returns text cells on the master stream from a single output
// register. A byte that produces no cell is taken in any cycle; a byte that
// produces a cell is taken when the output register is empty or being read in
// that cycle. An attribute byte that starts a both-repeated run of n cells
// places the first cell at once and then holds tready low while the controller
// emits the other n-1 cells, one per cycle when the cell stream does not stall
// and one cell per free output slot when it does. When the image ends inside
// such a run the rest of the run is dropped and tready returns once the
// registered finished flag ends the burst. Writing the compressed register
// restarts parsing at a run header; write configuration only while no cells
// are pending. After the cell that completes the last row every byte is
// accepted and ignored until reset. There is no clearing pass after reset.
module xbin_cell_stream_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic [xbin_pkg::CfgAW-1:0]  cfg_addr_i,
  input  logic [xbin_pkg::CfgW-1:0]   cfg_wdata_i,
  // input bytes
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [xbin_pkg::ByteW-1:0]  s_axis_tdata,   // [7:0] data_byte
  // output cells
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [7:0] char_code, [11:8] foreground, [15:12] background,
  // [31:16] column, [47:32] row
  output logic [xbin_pkg::CellW-1:0]  m_axis_tdata,
  output logic                        m_axis_tlast,   // last_of_run
  output logic                        m_axis_tuser    // image_done
);
  import xbin_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Parsing controller
  xbin_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tvalid_i (s_axis_tvalid),
    .tready_o (s_axis_tready),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Datapath
  xbin_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .byte_i      (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tlast_o   (m_axis_tlast),
    .m_tuser_o   (m_axis_tuser)
  );

`ifndef ASSERT_OFF
  // a cell is never placed over one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && !status.finished) |-> (!m_axis_tvalid || m_axis_tready))
    else $error("cell emitted while output register is full");

  // nothing follows the cell that completes the image
  a_done_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tuser) |=> !m_axis_tvalid)
    else $error("cell emitted after image done");

  // a header byte never produces a cell
  a_head_no_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.ld_head && cmd.emit))
    else $error("run header produced a cell");
`endif

endmodule

// ===== src/xbin_ctrl.sv =====
// Byte parsing controller for the XBin cell stream decoder.
// Depends on xbin_pkg; drives the datapath through dp_cmd_t.
`timescale 1ns / 1ps

module xbin_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tvalid_i,
  output logic                tready_o,
  input  xbin_pkg::dp_status_t status_i,
  output xbin_pkg::dp_cmd_t    cmd_o
);
  import xbin_pkg::*;

  typedef enum logic [2:0] {
    ST_HEAD,    // run header, or character byte in raw mode
    ST_RAWATT,  // attribute byte in raw mode
    ST_FIRST,   // first byte of a run step
    ST_SECOND,  // attribute byte after a character
    ST_STREAM,  // streamed byte against a held value
    ST_BURST    // both-repeated run, one cell per cycle while the output slot is free
  } state_e;

  state_e state_q, state_d;
  logic   needs_slot;
  logic   fire;

  // Does a byte in this state produce a cell?
  always_comb begin
    if (!status_i.compressed) begin
      needs_slot = (state_q == ST_RAWATT);
    end else begin
      needs_slot = (state_q == ST_SECOND) || (state_q == ST_STREAM);
    end
  end

  assign tready_o = (state_q != ST_BURST) &&
                    (!needs_slot || status_i.slot_free || status_i.finished);
  assign fire     = tvalid_i && tready_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_BURST: begin
        if (status_i.finished) begin
          state_d = ST_HEAD;
        end else if (status_i.slot_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.last     = status_i.left_one;
          cmd_o.dec_left = 1'b1;
          if (status_i.left_one) begin
            state_d = ST_HEAD;
          end
        end
      end
      default: begin
        if (fire && !status_i.compressed) begin
          // raw pairs: character then attribute
          if (state_q == ST_RAWATT) begin
            cmd_o.ld_attr        = 1'b1;
            cmd_o.emit           = 1'b1;
            cmd_o.attr_from_byte = 1'b1;
            cmd_o.last           = 1'b1;
            state_d              = ST_HEAD;
          end else begin
            cmd_o.ld_char = 1'b1;
            state_d       = ST_RAWATT;
          end
        end else if (fire) begin
          unique case (state_q)
            ST_FIRST: begin
              unique case (status_i.run_type)
                RUN_LITERAL: begin
                  cmd_o.ld_char = 1'b1;
                  state_d       = ST_SECOND;
                end
                RUN_CHAR: begin
                  cmd_o.ld_char = 1'b1;
                  state_d       = ST_STREAM;
                end
                RUN_ATTR: begin
                  cmd_o.ld_attr = 1'b1;
                  state_d       = ST_STREAM;
                end
                default: begin
                  cmd_o.ld_char = 1'b1;
                  state_d       = ST_SECOND;
                end
              endcase
            end
            ST_SECOND: begin
              cmd_o.ld_attr        = 1'b1;
              cmd_o.emit           = 1'b1;
              cmd_o.attr_from_byte = 1'b1;
              cmd_o.dec_left       = 1'b1;
              if (status_i.run_type == RUN_BOTH) begin
                cmd_o.last = status_i.left_one;
                state_d    = status_i.left_one ? ST_HEAD : ST_BURST;
              end else begin
                cmd_o.last = 1'b1;
                state_d    = status_i.left_one ? ST_HEAD : ST_FIRST;
              end
            end
            ST_STREAM: begin
              cmd_o.emit     = 1'b1;
              cmd_o.last     = 1'b1;
              cmd_o.dec_left = 1'b1;
              if (status_i.run_type == RUN_CHAR) begin
                cmd_o.ld_attr        = 1'b1;
                cmd_o.attr_from_byte = 1'b1;
              end else begin
                cmd_o.ld_char        = 1'b1;
                cmd_o.char_from_byte = 1'b1;
              end
              state_d = status_i.left_one ? ST_HEAD : ST_STREAM;
            end
            default: begin
              // run header
              cmd_o.ld_head = 1'b1;
              state_d       = ST_FIRST;
            end
          endcase
        end
      end
    endcase
    // a mode write restarts parsing
    if (status_i.mode_wr) begin
      state_d = ST_HEAD;
    end
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HEAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/xbin_datapath.sv =====
// Datapath of the XBin cell stream decoder: config registers, held values,
// run counter, cell position and the output register. Depends on xbin_pkg.
`timescale 1ns / 1ps

module xbin_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [xbin_pkg::CfgAW-1:0]         cfg_addr_i,
  input  logic [xbin_pkg::CfgW-1:0]          cfg_wdata_i,
  input  logic [xbin_pkg::ByteW-1:0]         byte_i,
  input  xbin_pkg::dp_cmd_t                  cmd_i,
  output xbin_pkg::dp_status_t               status_o,
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  output logic [xbin_pkg::CellW-1:0]         m_tdata_o,
  output logic                               m_tlast_o,
  output logic                               m_tuser_o
);
  import xbin_pkg::*;

  logic [CfgW-1:0]  columns_q, rows_q;
  logic             compressed_q;
  logic             mode_wr;
  run_type_e        run_type_q;
  logic [LeftW-1:0] run_left_q, run_left_d;
  logic [ByteW-1:0] held_char_q, held_attr_q;
  logic [PosW-1:0]  col_q, col_d, row_q, row_d;
  logic             finished_q, finished_d;
  logic             out_valid_q, out_valid_d;
  logic [CellW-1:0] out_cell_q;
  logic             out_last_q, out_done_q;

  logic [ByteW-1:0] cell_char, cell_attr;
  logic [PosW:0]    col_inc;
  logic [PosW-1:0]  row_inc;
  logic             wrap, done, load;

  assign mode_wr = cfg_we_i && (cfg_addr_i == CFG_COMPRESSED);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q    <= ColumnsReset;
      rows_q       <= RowsReset;
      compressed_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == CFG_COLUMNS) begin
        columns_q <= cfg_wdata_i;
      end
      if (cfg_addr_i == CFG_ROWS) begin
        rows_q <= cfg_wdata_i;
      end
      if (cfg_addr_i == CFG_COMPRESSED) begin
        compressed_q <= cfg_wdata_i[0];
      end
    end
  end

  // Cell values and next position
  assign cell_char = cmd_i.char_from_byte ? byte_i : held_char_q;
  assign cell_attr = cmd_i.attr_from_byte ? byte_i : held_attr_q;
  assign col_inc   = {1'b0, col_q} + {{PosW{1'b0}}, 1'b1};
  assign wrap      = col_inc[PosW] || (col_inc[PosW-1:0] >= columns_q);
  assign row_inc   = row_q + {{(PosW-1){1'b0}}, 1'b1};
  assign done      = wrap && (row_inc >= rows_q);

  // Emit: dropped once finished or when the row lies past the image
  always_comb begin
    load       = 1'b0;
    col_d      = col_q;
    row_d      = row_q;
    finished_d = finished_q;
    if (cmd_i.emit && !finished_q) begin
      if (row_q >= rows_q) begin
        finished_d = 1'b1;
      end else begin
        load = 1'b1;
        if (wrap) begin
          col_d      = '0;
          row_d      = row_inc;
          finished_d = done;
        end else begin
          col_d = col_inc[PosW-1:0];
        end
      end
    end
  end

  // Run counter
  always_comb begin
    run_left_d = run_left_q;
    if (mode_wr) begin
      run_left_d = '0;
    end else if (cmd_i.ld_head) begin
      run_left_d = {1'b0, byte_i[5:0]} + {{(LeftW-1){1'b0}}, 1'b1};
    end else if (cmd_i.dec_left && (run_left_q != '0)) begin
      run_left_d = run_left_q - {{(LeftW-1){1'b0}}, 1'b1};
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_type_q <= RUN_LITERAL;
      run_left_q <= '0;
      col_q      <= '0;
      row_q      <= '0;
      finished_q <= 1'b0;
    end else begin
      if (cmd_i.ld_head) begin
        run_type_q <= run_type_e'(byte_i[7:6]);
      end
      run_left_q <= run_left_d;
      col_q      <= col_d;
      row_q      <= row_d;
      finished_q <= finished_d;
    end
  end

  // Held character and attribute
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_char) begin
      held_char_q <= byte_i;
    end
    if (cmd_i.ld_attr) begin
      held_attr_q <= byte_i;
    end
  end

  // Output register
  assign out_valid_d = load ? 1'b1 : (m_tready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_cell_q <= {row_q, col_q, cell_attr[7:4], cell_attr[3:0], cell_char};
      out_last_q <= cmd_i.last || done;
      out_done_q <= done;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_cell_q;
  assign m_tlast_o  = out_last_q;
  assign m_tuser_o  = out_done_q;

  // Status
  assign status_o.compressed = compressed_q;
  assign status_o.mode_wr    = mode_wr;
  assign status_o.finished   = finished_q;
  assign status_o.left_one   = (run_left_q == {{(LeftW-1){1'b0}}, 1'b1});
  assign status_o.slot_free  = !out_valid_q || m_tready_i;
  assign status_o.run_type   = run_type_q;

endmodule

// ===== tb/xbin_cell_checker.sv =====
// Checker for the XBin cell stream decoder: watches the config port and both
// streams, predicts the cells of every byte taken and compares them in order.
// Depends on xbin_pkg.
`timescale 1ns / 1ps

module xbin_cell_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [xbin_pkg::CfgAW-1:0]  cfg_addr_i,
  input  logic [xbin_pkg::CfgW-1:0]   cfg_wdata_i,
  input  logic                        byte_valid_i,
  input  logic                        byte_ready_i,
  input  logic [xbin_pkg::ByteW-1:0]  byte_data_i,
  input  logic                        cell_valid_i,
  input  logic                        cell_ready_i,
  input  logic [xbin_pkg::CellW-1:0]  cell_data_i,
  input  logic                        cell_last_i,
  input  logic                        cell_done_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o,
  output logic [xbin_pkg::PosW-1:0]   next_row_o
);
  import xbin_pkg::*;

  typedef enum logic [2:0] {
    PH_HEAD,      // run header, or character byte in raw mode
    PH_RAW_ATTR,  // attribute byte of a raw pair
    PH_FIRST,     // first byte after a run header
    PH_SECOND,    // attribute byte of a pair
    PH_STREAM     // repeated part of a char or attr run
  } parse_phase_e;

  typedef struct packed {
    logic [ByteW-1:0] char_code;
    logic [NibW-1:0]  fg;
    logic [NibW-1:0]  bg;
    logic [PosW-1:0]  col;
    logic [PosW-1:0]  row;
    logic             last;
    logic             done;
  } cell_t;

  // Predicted decoder state and configuration
  logic [CfgW-1:0]  cols_q;
  logic [CfgW-1:0]  rows_q;
  logic             compressed_q;
  parse_phase_e     phase_q;
  run_type_e        run_type_q;
  logic [LeftW-1:0] run_left_q;
  logic [ByteW-1:0] held_char_q;
  logic [ByteW-1:0] held_attr_q;
  logic [PosW-1:0]  col_q;
  logic [PosW-1:0]  row_q;
  logic             finished_q;

  cell_t       expected_cells[$];
  cell_t       byte_cells[$];
  int unsigned mismatches;

  // One cell at the current position; dropped once the image is full
  task automatic place_cell(input logic [ByteW-1:0] ch, input logic [ByteW-1:0] attr);
    cell_t c;
    if (finished_q) return;
    if (row_q >= rows_q) begin
      finished_q = 1'b1;
      return;
    end
    c.char_code = ch;
    c.fg        = attr[3:0];
    c.bg        = attr[7:4];
    c.col       = col_q;
    c.row       = row_q;
    c.last      = 1'b0;
    c.done      = 1'b0;
    col_q = col_q + 1'b1;
    // wrap also covers a width of zero and a column past a lowered width
    if (col_q >= cols_q || col_q == '0) begin
      col_q = '0;
      row_q = row_q + 1'b1;
      if (row_q >= rows_q) begin
        finished_q = 1'b1;
        c.done     = 1'b1;
      end
    end
    byte_cells.push_back(c);
  endtask

  task automatic advance_run();
    if (run_left_q != '0) run_left_q = run_left_q - 1'b1;
    if (run_left_q == '0) phase_q = PH_HEAD;
  endtask

  // Cells caused by one accepted byte, queued with last_of_run on the final one
  task automatic decode_byte(input logic [ByteW-1:0] b);
    int    k;
    cell_t c;
    byte_cells.delete();
    if (finished_q) return;
    if (!compressed_q) begin
      if (phase_q == PH_RAW_ATTR) begin
        held_attr_q = b;
        place_cell(held_char_q, held_attr_q);
        phase_q = PH_HEAD;
      end else begin
        held_char_q = b;
        phase_q     = PH_RAW_ATTR;
      end
    end else begin
      case (phase_q)
        PH_FIRST: begin
          case (run_type_q)
            RUN_LITERAL: begin
              held_char_q = b;
              phase_q     = PH_SECOND;
            end
            RUN_CHAR: begin
              held_char_q = b;
              phase_q     = PH_STREAM;
            end
            RUN_ATTR: begin
              held_attr_q = b;
              phase_q     = PH_STREAM;
            end
            default: begin
              held_char_q = b;
              phase_q     = PH_SECOND;
            end
          endcase
        end
        PH_SECOND: begin
          held_attr_q = b;
          if (run_type_q == RUN_BOTH) begin
            for (k = 0; k < run_left_q && k < 64; k++) place_cell(held_char_q, held_attr_q);
            run_left_q = '0;
            phase_q    = PH_HEAD;
          end else begin
            place_cell(held_char_q, held_attr_q);
            phase_q = PH_FIRST;
            advance_run();
          end
        end
        PH_STREAM: begin
          if (run_type_q == RUN_CHAR) held_attr_q = b;
          else held_char_q = b;
          place_cell(held_char_q, held_attr_q);
          advance_run();
        end
        default: begin
          run_type_q = run_type_e'(b[7:6]);
          run_left_q = {1'b0, b[5:0]} + 1'b1;
          phase_q    = PH_FIRST;
        end
      endcase
    end
    for (k = 0; k < byte_cells.size(); k++) begin
      c      = byte_cells[k];
      c.last = (k == byte_cells.size() - 1);
      expected_cells.push_back(c);
    end
  endtask

  task automatic write_reg(input logic [CfgAW-1:0] idx, input logic [CfgW-1:0] value);
    case (cfg_idx_e'(idx))
      CFG_COLUMNS: cols_q = value;
      CFG_ROWS:    rows_q = value;
      CFG_COMPRESSED: begin
        // mode write restarts parsing and drops any open run
        compressed_q = value[0];
        phase_q      = PH_HEAD;
        run_left_q   = '0;
      end
      default: ;
    endcase
  endtask

  task automatic compare_cell(input cell_t got);
    cell_t want;
    if (expected_cells.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: cell with none expected: ch=%02h fg=%0h bg=%0h col=%0d row=%0d last=%0b done=%0b",
                 $realtime, got.char_code, got.fg, got.bg, got.col, got.row, got.last, got.done);
      return;
    end
    want = expected_cells.pop_front();
    if (got.char_code !== want.char_code || got.fg !== want.fg || got.bg !== want.bg ||
        got.col !== want.col || got.row !== want.row || got.last !== want.last ||
        got.done !== want.done) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: cell mismatch", $realtime);
        $display("  expected ch=%02h fg=%0h bg=%0h col=%0d row=%0d last=%0b done=%0b",
                 want.char_code, want.fg, want.bg, want.col, want.row, want.last, want.done);
        $display("  actual   ch=%02h fg=%0h bg=%0h col=%0d row=%0d last=%0b done=%0b",
                 got.char_code, got.fg, got.bg, got.col, got.row, got.last, got.done);
      end
    end
  endtask

  // Output first, then config, then input: a cell leaving now was predicted earlier
  always @(posedge clk_i or negedge rst_ni) begin
    cell_t got;
    if (!rst_ni) begin
      cols_q       = ColumnsReset;
      rows_q       = RowsReset;
      compressed_q = 1'b0;
      phase_q      = PH_HEAD;
      run_type_q   = RUN_LITERAL;
      run_left_q   = '0;
      held_char_q  = '0;
      held_attr_q  = '0;
      col_q        = '0;
      row_q        = '0;
      finished_q   = 1'b0;
      mismatches   = 0;
      expected_cells.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      next_row_o   <= '0;
    end else begin
      if (cell_valid_i && cell_ready_i) begin
        got.char_code = cell_data_i[7:0];
        got.fg        = cell_data_i[11:8];
        got.bg        = cell_data_i[15:12];
        got.col       = cell_data_i[31:16];
        got.row       = cell_data_i[47:32];
        got.last      = cell_last_i;
        got.done      = cell_done_i;
        compare_cell(got);
      end
      if (cfg_we_i) write_reg(cfg_addr_i, cfg_wdata_i);
      if (byte_valid_i && byte_ready_i) decode_byte(byte_data_i);
      fail_count_o <= mismatches;
      pending_o    <= expected_cells.size();
      next_row_o   <= row_q;
    end
  end

endmodule

// ===== tb/tb_xbin_cell_stream_decoder.sv =====
// Testbench top for the XBin cell stream decoder: clock, reset, byte and
// config stimulus, random stalls on the cell stream, and the verdict.
// Depends on xbin_pkg, xbin_cell_stream_decoder and xbin_cell_checker.
`timescale 1ns / 1ps

module tb_xbin_cell_stream_decoder;
  import xbin_pkg::*;

  localparam int unsigned RandomItems = 200;
  localparam int unsigned QuietItems  = 40;
  localparam int unsigned CycleLimit  = 500000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgAW-1:0]   cfg_addr;
  logic [CfgW-1:0]    cfg_wdata;
  logic               s_tvalid;
  logic               s_tready;
  logic [ByteW-1:0]   s_tdata;
  logic               m_tvalid;
  logic               m_tready;
  logic [CellW-1:0]   m_tdata;
  logic               m_tlast;
  logic               m_tuser;

  int unsigned        fail_count;
  int unsigned        pending;
  logic [PosW-1:0]    next_row;
  int unsigned        items_sent = 0;
  int unsigned        cycle_count = 0;
  bit                 gaps_on = 1'b1;
  bit                 stall_on = 1'b1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  xbin_cell_stream_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast),
    .m_axis_tuser  (m_tuser)
  );

  xbin_cell_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_wdata_i  (cfg_wdata),
    .byte_valid_i (s_tvalid),
    .byte_ready_i (s_tready),
    .byte_data_i  (s_tdata),
    .cell_valid_i (m_tvalid),
    .cell_ready_i (m_tready),
    .cell_data_i  (m_tdata),
    .cell_last_i  (m_tlast),
    .cell_done_i  (m_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .next_row_o   (next_row)
  );

  // Cell sink with random stall bursts
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      m_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] value);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted cell has come out
  task automatic drain(input int unsigned tail);
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Well-formed compressed run with random type, count and content
  task automatic send_run();
    logic [1:0] kind;
    logic [5:0] count;
    int         k;
    kind  = 2'($urandom_range(0, 3));
    count = 6'(($urandom_range(0, 15) == 0) ? $urandom_range(0, 63)
                                             : $urandom_range(0, 7));
    send_byte({kind, count});
    case (run_type_e'(kind))
      RUN_LITERAL: begin
        for (k = 0; k <= count; k++) begin
          send_byte(8'($urandom_range(0, 255)));
          send_byte(8'($urandom_range(0, 255)));
        end
      end
      RUN_BOTH: begin
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
      end
      default: begin
        for (k = 0; k <= count + 1; k++) send_byte(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  initial begin
    int unsigned     target;
    logic [CfgW-1:0] width;
    bit              mode;

    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_COLUMNS;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Raw pairs on the reset configuration, byte extremes
    send_byte(8'h00); send_byte(8'h00);
    send_byte(8'hFF); send_byte(8'hFF);
    send_byte(8'h41); send_byte(8'h1E);
    drain(8);

    // Every run type, widest row, single row
    write_reg(CFG_COLUMNS, 16'hFFFF);
    write_reg(CFG_ROWS, 16'd1);
    write_reg(CFG_COMPRESSED, 16'd1);
    send_byte({RUN_LITERAL, 6'd0}); send_byte(8'h7F); send_byte(8'h80);
    send_byte({RUN_CHAR, 6'd1});    send_byte(8'h55); send_byte(8'h01); send_byte(8'h10);
    send_byte({RUN_ATTR, 6'd1});    send_byte(8'hAB); send_byte(8'h30); send_byte(8'h31);
    // both-repeated run of the full 64 cells, then of one cell
    send_byte({RUN_BOTH, 6'd63});   send_byte(8'hDB); send_byte(8'h4F);
    send_byte({RUN_BOTH, 6'd0});    send_byte(8'h20); send_byte(8'h07);
    drain(8);

    // Random phases; each starts idle with a fresh configuration
    target = items_sent + RandomItems;
    while (items_sent < target) begin
      if (items_sent + QuietItems >= target) begin
        gaps_on  = 1'b0;
        stall_on = 1'b0;
      end else begin
        gaps_on  = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
      end
      case ($urandom_range(0, 5))
        0:       width = 16'd0;
        1:       width = 16'd1;
        2:       width = 16'hFFFF;
        default: width = 16'($urandom_range(2, 100));
      endcase
      mode = 1'($urandom_range(0, 1));
      write_reg(CFG_COLUMNS, width);
      write_reg(CFG_ROWS, ($urandom_range(0, 1) != 0) ? 16'hFFFF
                                                      : 16'($urandom_range(20000, 65534)));
      write_reg(CFG_COMPRESSED, {15'd0, mode});
      repeat ($urandom_range(10, 40)) begin
        if (items_sent >= target) break;
        // no idling in the closing part of the run
        if (items_sent + QuietItems >= target) begin
          gaps_on  = 1'b0;
          stall_on = 1'b0;
        end
        if (!mode || $urandom_range(0, 7) == 0) send_byte(8'($urandom_range(0, 255)));
        else send_run();
      end
      drain(8);
    end
    gaps_on  = 1'b0;
    stall_on = 1'b0;

    // Finish the image: either inside a both-repeated run or by lowering rows
    if ($urandom_range(0, 2) != 0) begin
      write_reg(CFG_COLUMNS, 16'($urandom_range(1, 3)));
      write_reg(CFG_ROWS, next_row + 1'b1);
      write_reg(CFG_COMPRESSED, 16'd1);
      send_byte({RUN_BOTH, 6'd63});
      send_byte(8'($urandom_range(0, 255)));
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      write_reg(CFG_ROWS, 16'($urandom_range(0, next_row)));
      write_reg(CFG_COMPRESSED, 16'd0);
      send_byte(8'($urandom_range(0, 255)));
      send_byte(8'($urandom_range(0, 255)));
    end
    // bytes after the image is done are taken and ignored
    repeat (6) send_byte(8'($urandom_range(0, 255)));
    drain(20);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
